### rtl/core/hmbs_pkg.sv
// Shared constants, types and helper functions for the heightmap bilinear sampler.
`timescale 1ns / 1ps

package hmbs_pkg;

  localparam int DIM_BITS    = 8;
  localparam int HEIGHT_BITS = 16;
  localparam int FRAC_BITS   = 16;

  localparam int SIZE_W   = DIM_BITS + 1;
  localparam int COORD_W  = FRAC_BITS + 1;
  localparam int PROD_W   = COORD_W + DIM_BITS;
  localparam int IDX_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W    = HEIGHT_BITS + FRAC_BITS + 1;
  localparam int GRID_MAX = 1 << DIM_BITS;

  // Four banks split by the parity of column and row.
  localparam int NUM_BANKS  = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_AW    = 2 * (DIM_BITS - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // Slave-side tdata layout, lowest field first.
  localparam int X_LSB     = 0;
  localparam int Z_LSB     = X_LSB + DIM_BITS;
  localparam int H_LSB     = Z_LSB + DIM_BITS;
  localparam int U_LSB     = H_LSB + HEIGHT_BITS;
  localparam int V_LSB     = U_LSB + COORD_W;
  localparam int IN_BITS   = V_LSB + COORD_W;
  localparam int TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  // Result buffer; it also bounds the number of queries in flight.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PW    = $clog2(OUT_DEPTH);
  localparam int CNT_W     = OUT_PW + 1;

  localparam logic [HEIGHT_BITS-1:0] HSIGN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
  localparam logic [COORD_W-1:0]     ONE   = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  // Grid sizes below 2 act as 2, sizes above the maximum act as the maximum.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [SIZE_W-1:0] s;
    if (r < SIZE_W'(2)) begin
      s = SIZE_W'(2);
    end else if (r > SIZE_W'(GRID_MAX)) begin
      s = SIZE_W'(GRID_MAX);
    end else begin
      s = r;
    end
    return s;
  endfunction

endpackage

### rtl/core/hmbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module hmbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/heightmap_bilinear_sampler_unit.sv
// Top level of the heightmap bilinear sampler: banked height store and blend pipeline.
// A query result passes the stage 1, 2 and 3 registers and the result buffer before m_tvalid.
// Throughput: one write or query beat per cycle while s_tready is high; the four height
// reads are served at once by four RAM banks selected by column and row parity.
// Up to 8 query results may be in flight or held; s_tready drops only when all are taken.
// Reset sets both grid sizes to 256 and empties the pipeline; the height store is not cleared.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_unit
  import hmbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // write_x, write_z, write_height, query_u, query_v, zero fill
  input  logic [TDATA_W-1:0]     s_tdata,
  // operation
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // sampled_height
  output logic [HEIGHT_BITS-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  reg_idx_t               cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic [SIZE_W-1:0] eff_w, eff_h, last_w, last_h;

  logic              accept;
  logic [DIM_BITS-1:0]    in_x, in_z;
  logic [HEIGHT_BITS-1:0] in_h;
  logic [COORD_W-1:0]     in_u, in_v;
  logic                   in_grid;
  logic [PROD_W-1:0]      prod_u, prod_v;

  // Stage 1: scaled coordinates and pending write
  logic                   s1_query, s1_wr_en;
  logic [PROD_W-1:0]      s1_prod_u, s1_prod_v;
  logic [DIM_BITS-1:0]    s1_wr_x, s1_wr_z;
  logic [HEIGHT_BITS-1:0] s1_wr_h;

  logic [IDX_W-1:0]       idx_u, idx_v;
  logic [DIM_BITS-1:0]    x0, x1, z0, z1;
  logic [SIZE_W-1:0]      x1_inc, z1_inc;

  logic [HEIGHT_BITS-1:0] bank_rd [NUM_BANKS];

  // Stage 2: bank data arrives
  logic                   s2_query;
  logic [FRAC_BITS-1:0]   s2_fx, s2_fz;
  logic                   s2_x0p, s2_x1p, s2_z0p, s2_z1p;
  logic [HEIGHT_BITS-1:0] h00, h10, h01, h11;
  logic [COORD_W-1:0]     inv_fx;
  logic [SUM_W-1:0]       lo_sum, hi_sum;

  // Stage 3: row blends
  logic                   s3_query;
  logic [FRAC_BITS-1:0]   s3_fz;
  logic [HEIGHT_BITS-1:0] s3_lo, s3_hi;
  logic [COORD_W-1:0]     inv_fz;
  logic [SUM_W-1:0]       out_sum;
  logic [HEIGHT_BITS-1:0] result;

  // Result buffer
  logic [HEIGHT_BITS-1:0] out_buf [OUT_DEPTH];
  logic [OUT_PW-1:0]      wr_ptr, rd_ptr;
  logic [CNT_W-1:0]       fifo_cnt, fifo_cnt_next;
  logic [CNT_W-1:0]       pending, pending_next;
  logic                   out_beat, in_query;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(GRID_MAX);
      grid_height <= SIZE_W'(GRID_MAX);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w  = eff_size(grid_width);
  assign eff_h  = eff_size(grid_height);
  assign last_w = eff_w - SIZE_W'(1);
  assign last_h = eff_h - SIZE_W'(1);

  // ---------------- stage 0: accept and scale ----------------
  assign accept   = s_tvalid & s_tready;
  assign in_query = accept && (op_t'(s_tuser[0]) == OP_QUERY);
  assign in_x     = s_tdata[X_LSB +: DIM_BITS];
  assign in_z     = s_tdata[Z_LSB +: DIM_BITS];
  assign in_h     = s_tdata[H_LSB +: HEIGHT_BITS];
  assign in_u     = s_tdata[U_LSB +: COORD_W];
  assign in_v     = s_tdata[V_LSB +: COORD_W];
  assign in_grid  = ({1'b0, in_x} < eff_w) && ({1'b0, in_z} < eff_h);
  assign prod_u   = PROD_W'(in_u) * PROD_W'(last_w[DIM_BITS-1:0]);
  assign prod_v   = PROD_W'(in_v) * PROD_W'(last_h[DIM_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_query <= 1'b0;
      s1_wr_en <= 1'b0;
    end else begin
      s1_query <= in_query;
      s1_wr_en <= accept && (op_t'(s_tuser[0]) == OP_WRITE) && in_grid;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod_u <= prod_u;
    s1_prod_v <= prod_v;
    s1_wr_x   <= in_x;
    s1_wr_z   <= in_z;
    s1_wr_h   <= in_h;
  end

  // ---------------- stage 1: index split and bank access ----------------
  assign idx_u = s1_prod_u[PROD_W-1:FRAC_BITS];
  assign idx_v = s1_prod_v[PROD_W-1:FRAC_BITS];

  // A coordinate above one clamps to the edge; the fraction is kept as computed.
  assign x0 = (IDX_W'(idx_u) > IDX_W'(last_w)) ? last_w[DIM_BITS-1:0] : idx_u[DIM_BITS-1:0];
  assign z0 = (IDX_W'(idx_v) > IDX_W'(last_h)) ? last_h[DIM_BITS-1:0] : idx_v[DIM_BITS-1:0];
  assign x1_inc = {1'b0, x0} + SIZE_W'(1);
  assign z1_inc = {1'b0, z0} + SIZE_W'(1);
  assign x1 = (x1_inc > last_w) ? last_w[DIM_BITS-1:0] : x1_inc[DIM_BITS-1:0];
  assign z1 = (z1_inc > last_h) ? last_h[DIM_BITS-1:0] : z1_inc[DIM_BITS-1:0];

  // Neighbors differ by one, so each bank serves at most one of the four reads.
  // Writes and reads of different beats never meet in the same cycle here, and a
  // write lands before any later query reads, so no forwarding is needed.
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic PX = 1'(b % 2);
    localparam logic PZ = 1'(b / 2);
    logic [DIM_BITS-1:0] xs, zs;
    logic                bank_we;

    assign xs      = (x0[0] == PX) ? x0 : x1;
    assign zs      = (z0[0] == PZ) ? z0 : z1;
    assign bank_we = s1_wr_en && (s1_wr_x[0] == PX) && (s1_wr_z[0] == PZ);

    hmbs_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we),
      .waddr ({s1_wr_z[DIM_BITS-1:1], s1_wr_x[DIM_BITS-1:1]}),
      .wdata (s1_wr_h),
      .re    (s1_query),
      .raddr ({zs[DIM_BITS-1:1], xs[DIM_BITS-1:1]}),
      .rdata (bank_rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_query <= 1'b0;
    end else begin
      s2_query <= s1_query;
    end
  end

  always_ff @(posedge clk) begin
    s2_fx  <= s1_prod_u[FRAC_BITS-1:0];
    s2_fz  <= s1_prod_v[FRAC_BITS-1:0];
    s2_x0p <= x0[0];
    s2_x1p <= x1[0];
    s2_z0p <= z0[0];
    s2_z1p <= z1[0];
  end

  // ---------------- stage 2: blend along x ----------------
  // Heights are blended in offset binary so the truncation floors as on signed values.
  assign h00 = bank_rd[{s2_z0p, s2_x0p}] ^ HSIGN;
  assign h10 = bank_rd[{s2_z0p, s2_x1p}] ^ HSIGN;
  assign h01 = bank_rd[{s2_z1p, s2_x0p}] ^ HSIGN;
  assign h11 = bank_rd[{s2_z1p, s2_x1p}] ^ HSIGN;

  assign inv_fx = ONE - COORD_W'(s2_fx);
  assign lo_sum = SUM_W'(h00) * SUM_W'(inv_fx) + SUM_W'(h10) * SUM_W'(s2_fx);
  assign hi_sum = SUM_W'(h01) * SUM_W'(inv_fx) + SUM_W'(h11) * SUM_W'(s2_fx);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_query <= 1'b0;
    end else begin
      s3_query <= s2_query;
    end
  end

  always_ff @(posedge clk) begin
    s3_fz <= s2_fz;
    s3_lo <= lo_sum[FRAC_BITS +: HEIGHT_BITS];
    s3_hi <= hi_sum[FRAC_BITS +: HEIGHT_BITS];
  end

  // ---------------- stage 3: blend along z ----------------
  assign inv_fz  = ONE - COORD_W'(s3_fz);
  assign out_sum = SUM_W'(s3_lo) * SUM_W'(inv_fz) + SUM_W'(s3_hi) * SUM_W'(s3_fz);
  assign result  = out_sum[FRAC_BITS +: HEIGHT_BITS] ^ HSIGN;

  // ---------------- result buffer and credit count ----------------
  assign out_beat = m_tvalid & m_tready;
  assign m_tvalid = (fifo_cnt != '0);
  assign m_tdata  = out_buf[rd_ptr];
  assign s_tready = (pending != CNT_W'(OUT_DEPTH));

  always_comb begin
    pending_next  = pending;
    fifo_cnt_next = fifo_cnt;
    if (in_query && !out_beat) begin
      pending_next = pending + CNT_W'(1);
    end else if (!in_query && out_beat) begin
      pending_next = pending - CNT_W'(1);
    end
    if (s3_query && !out_beat) begin
      fifo_cnt_next = fifo_cnt + CNT_W'(1);
    end else if (!s3_query && out_beat) begin
      fifo_cnt_next = fifo_cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      fifo_cnt <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
    end else begin
      pending  <= pending_next;
      fifo_cnt <= fifo_cnt_next;
      if (s3_query) begin
        wr_ptr <= wr_ptr + OUT_PW'(1);
      end
      if (out_beat) begin
        rd_ptr <= rd_ptr + OUT_PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_query) begin
      out_buf[wr_ptr] <= result;
    end
  end

endmodule

### rtl/core/hmbs_checker.sv
// Port-level assertions for the heightmap bilinear sampler and their binding.
`timescale 1ns / 1ps

module hmbs_checker
  import hmbs_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [TDATA_W-1:0]     s_tdata,
  input logic [0:0]             s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [HEIGHT_BITS-1:0] m_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input reg_idx_t               cfg_index,
  input logic [SIZE_W-1:0]      cfg_data
);

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat offered right after reset");

  // A query beat always has its result on offer once it has passed stages 1 to 3.
  a_query_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (op_t'(s_tuser[0]) == OP_QUERY)) |-> ##4 m_tvalid)
    else $error("query result missing four cycles after its beat");

  // A held result stays offered with the same value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed or vanished");

  // Configuration writes are never stalled.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind heightmap_bilinear_sampler_unit hmbs_checker u_hmbs_checker (.*);
